>>> sv/lnws_pkg.sv
// Shared types, constants and helpers for the LCD nibble write sequencer.
// No dependencies; every other file refers to it by scoped names.
package lnws_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WAIT_W     = 16;
    localparam int STEP_W     = 4;

    // request operation codes
    localparam logic [2:0] FUNC_INIT    = 3'd0;
    localparam logic [2:0] FUNC_COMMAND = 3'd1;
    localparam logic [2:0] FUNC_DATA    = 3'd2;
    localparam logic [2:0] FUNC_CLEAR   = 3'd3;
    localparam logic [2:0] FUNC_CURSOR  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_GAP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_EXTRA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWERUP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_FIRST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SECOND = 3'd6;

    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CURSOR_ROW1    = 8'h80;
    localparam logic [7:0] CURSOR_ROW2    = 8'hC0;
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;
    localparam logic [3:0] NIB_MASK       = 4'hF;

    localparam logic [STEP_W-1:0] INIT_FIRST_BYTE_STEP = 4'd4;
    localparam logic [STEP_W-1:0] LAST_INIT_STEP       = 4'd11;
    localparam logic [STEP_W-1:0] LAST_BYTE_STEP       = 4'd1;

    // extra wait added after the low nibble of a byte
    typedef enum logic [1:0] {
        EXTRA_COMMAND,
        EXTRA_DATA,
        EXTRA_CLEAR
    } extra_t;

    typedef struct packed {
        logic       is_init;
        logic [7:0] byte_val;
        logic       rs;
        extra_t     extra;
    } desc_t;

    typedef struct packed {
        logic [9:0]  nibble_gap;
        logic [13:0] command_wait;
        logic [9:0]  data_wait;
        logic [13:0] clear_extra;
        logic [15:0] powerup_wait;
        logic [13:0] init_first_wait;
        logic [9:0]  init_second_wait;
    } cfg_t;

    // function set, display on, entry mode, clear
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h28;
            2'd1: b = 8'h0C;
            2'd2: b = 8'h06;
            2'd3: b = 8'h01;
        endcase
        return b;
    endfunction

    function automatic logic [WAIT_W-1:0] sat16(input logic [WAIT_W:0] v);
        return v[WAIT_W] ? {WAIT_W{1'b1}} : v[WAIT_W-1:0];
    endfunction

endpackage

>>> sv/lnws_front.sv
// Front end: takes request beats, decodes the operation and the byte to send,
// and pushes a write descriptor into the queue. Uses lnws_pkg.
module lnws_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_func,
    input  logic [7:0]       s_byte_value,
    input  logic [1:0]       s_row,
    input  logic [5:0]       s_column,
    output logic             push,
    output lnws_pkg::desc_t  push_desc,
    input  logic             q_full
);
    logic       known;
    logic [7:0] cursor_base;
    logic [7:0] cursor_byte;

    assign cursor_base = (s_row == 2'd1) ? lnws_pkg::CURSOR_ROW1 : lnws_pkg::CURSOR_ROW2;
    // column is one-based; adding 0xFF subtracts one mod 256
    assign cursor_byte = 8'(cursor_base + {2'b00, s_column} + 8'hFF);

    always_comb begin
        known              = 1'b1;
        push_desc.is_init  = 1'b0;
        push_desc.byte_val = s_byte_value;
        push_desc.rs       = 1'b0;
        push_desc.extra    = lnws_pkg::EXTRA_COMMAND;
        unique case (s_func)
            lnws_pkg::FUNC_INIT: begin
                push_desc.is_init = 1'b1;
            end
            lnws_pkg::FUNC_COMMAND: begin
            end
            lnws_pkg::FUNC_DATA: begin
                push_desc.rs    = 1'b1;
                push_desc.extra = lnws_pkg::EXTRA_DATA;
            end
            lnws_pkg::FUNC_CLEAR: begin
                push_desc.byte_val = lnws_pkg::CMD_CLEAR;
                push_desc.extra    = lnws_pkg::EXTRA_CLEAR;
            end
            lnws_pkg::FUNC_CURSOR: begin
                push_desc.byte_val = cursor_byte;
            end
            default: begin
                known = 1'b0;  // undefined operations are taken and dropped
            end
        endcase
    end

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready && known;

endmodule

>>> sv/lnws_queue.sv
// Short descriptor queue between front and back ends.
// Register-based circular buffer; uses lnws_pkg for the entry type.
module lnws_queue #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lnws_pkg::desc_t  push_desc,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output lnws_pkg::desc_t  q_desc
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lnws_pkg::desc_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_desc  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> sv/lnws_back.sv
// Back end: walks each queued descriptor one nibble write per cycle unless
// m_ready stalls, and holds beats in an output register. Uses lnws_pkg.
module lnws_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lnws_pkg::cfg_t                 cfg,
    input  logic                           q_valid,
    input  lnws_pkg::desc_t                q_desc,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_nibble,
    output logic                           m_reg_select,
    output logic [lnws_pkg::WAIT_W-1:0]    m_pre_wait_us,
    output logic [lnws_pkg::WAIT_W-1:0]    m_post_wait_us,
    output logic                           m_last
);
    localparam int W = lnws_pkg::WAIT_W;

    logic [lnws_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        m_valid_reg, m_valid_next;
    logic [3:0]                  nibble_reg;
    logic                        rs_reg;
    logic [W-1:0]                pre_reg, post_reg;
    logic                        last_reg;

    logic                        load;
    logic                        is_last;
    logic [3:0]                  nib;
    logic [7:0]                  cur_byte;
    logic [W-1:0]                pre;
    logic [W-1:0]                add_a, add_b;
    logic [W:0]                  post_sum;
    logic [1:0]                  init_idx;

    assign load = q_valid && (!m_valid_reg || m_ready);
    assign pop  = load && is_last;
    // init bytes start at step 4: byte index is step/2 - 2
    assign init_idx = 2'(step_reg[3:1] - 3'd2);

    always_comb begin
        add_a    = '0;
        add_b    = '0;
        pre      = '0;
        cur_byte = q_desc.byte_val;
        if (q_desc.is_init) begin
            is_last = (step_reg == lnws_pkg::LAST_INIT_STEP);
            if (step_reg < lnws_pkg::INIT_FIRST_BYTE_STEP) begin
                cur_byte = 8'h00;
                nib = (step_reg == 4'd3) ? lnws_pkg::NIB_FOUR_BIT : lnws_pkg::NIB_WAKE;
                if (step_reg == 4'd0) begin
                    pre   = cfg.powerup_wait;
                    add_a = W'(cfg.init_first_wait);
                end else if (step_reg == 4'd1) begin
                    add_a = W'(cfg.init_second_wait);
                end
            end else begin
                cur_byte = lnws_pkg::init_byte(init_idx);
                nib = step_reg[0] ? (cur_byte[3:0] & lnws_pkg::NIB_MASK) : cur_byte[7:4];
                if (step_reg[0]) begin
                    add_a = W'(cfg.command_wait);
                    if (is_last) begin
                        add_b = W'(cfg.clear_extra);
                    end
                end
            end
        end else begin
            is_last = (step_reg == lnws_pkg::LAST_BYTE_STEP);
            nib = step_reg[0] ? (cur_byte[3:0] & lnws_pkg::NIB_MASK) : cur_byte[7:4];
            if (step_reg[0]) begin
                unique case (q_desc.extra)
                    lnws_pkg::EXTRA_COMMAND: begin
                        add_a = W'(cfg.command_wait);
                    end
                    lnws_pkg::EXTRA_DATA: begin
                        add_a = W'(cfg.data_wait);
                    end
                    lnws_pkg::EXTRA_CLEAR: begin
                        add_a = W'(cfg.command_wait);
                        add_b = W'(cfg.clear_extra);
                    end
                    default: begin
                        add_a = '0;
                    end
                endcase
            end
        end
        post_sum = (W+1)'(cfg.nibble_gap) + {1'b0, add_a} + {1'b0, add_b};
    end

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
            step_next    = is_last ? '0 : step_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            nibble_reg <= nib;
            rs_reg     <= q_desc.rs;
            pre_reg    <= pre;
            post_reg   <= lnws_pkg::sat16(post_sum);
            last_reg   <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_nibble       = nibble_reg;
    assign m_reg_select   = rs_reg;
    assign m_pre_wait_us  = pre_reg;
    assign m_post_wait_us = post_reg;
    assign m_last         = last_reg;

    // a descriptor in mid-walk must stay at the queue head
    a_walk_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != '0 |-> q_valid)
        else $error("descriptor left queue head mid-walk");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_desc.is_init |-> step_reg <= lnws_pkg::LAST_BYTE_STEP)
        else $error("byte walk past second nibble");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        load && is_last |=> step_reg == '0 && m_valid && m_last)
        else $error("final write did not restart the walk");

    a_pre_only_first: assert property (@(posedge aclk) disable iff (!aresetn)
        load && step_reg != '0 |=> m_pre_wait_us == '0)
        else $error("pre-wait on a write other than the first");

endmodule

>>> sv/lcd_nibble_write_sequencer.sv
// Top level of the LCD nibble write sequencer: configuration registers,
// front end, descriptor queue and back end. Uses lnws_pkg, lnws_front,
// lnws_queue and lnws_back.
//
// Usage: each request beat on the s_ channel (func, byte_value, row,
// column) becomes a run of 4-bit bus write beats on the m_ channel, each
// with nibble, RS level, pre- and post-enable waits in microseconds, and
// m_last on the final write. Command, data, clear and set-cursor give two
// writes, init gives twelve, undefined operations are accepted and give none.
// The first write passes through the queue and then the back end's output
// register; the back end then issues one write per cycle while m_ready
// does not stall it. Requests keep being taken while the queue of
// QUEUE_DEPTH entries has room, so the front and back stall independently.
// When m_ready is low the current write holds in the output register and
// the walk pauses. Reset empties the queue, drops any pending write and
// loads the default wait registers. The user must write them via cfg_we,
// cfg_index and cfg_wdata only while the block is idle; nothing enforces it.
module lcd_nibble_write_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lnws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lnws_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_func,
    input  logic [7:0]                         s_byte_value,
    input  logic [1:0]                         s_row,
    input  logic [5:0]                         s_column,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [3:0]                         m_nibble,
    output logic                               m_reg_select,
    output logic [lnws_pkg::WAIT_W-1:0]        m_pre_wait_us,
    output logic [lnws_pkg::WAIT_W-1:0]        m_post_wait_us,
    output logic                               m_last
);
    lnws_pkg::cfg_t  cfg_reg, cfg_next;
    lnws_pkg::desc_t push_desc, q_desc;
    logic            push, q_full, q_valid, pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                lnws_pkg::CFG_NIBBLE_GAP:  cfg_next.nibble_gap       = cfg_wdata[9:0];
                lnws_pkg::CFG_COMMAND:     cfg_next.command_wait     = cfg_wdata[13:0];
                lnws_pkg::CFG_DATA:        cfg_next.data_wait        = cfg_wdata[9:0];
                lnws_pkg::CFG_CLEAR_EXTRA: cfg_next.clear_extra      = cfg_wdata[13:0];
                lnws_pkg::CFG_POWERUP:     cfg_next.powerup_wait     = cfg_wdata[15:0];
                lnws_pkg::CFG_INIT_FIRST:  cfg_next.init_first_wait  = cfg_wdata[13:0];
                lnws_pkg::CFG_INIT_SECOND: cfg_next.init_second_wait = cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nibble_gap       <= 10'd100;
            cfg_reg.command_wait     <= 14'd2000;
            cfg_reg.data_wait        <= 10'd100;
            cfg_reg.clear_extra      <= 14'd2000;
            cfg_reg.powerup_wait     <= 16'd20000;
            cfg_reg.init_first_wait  <= 14'd5000;
            cfg_reg.init_second_wait <= 10'd150;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lnws_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_byte_value (s_byte_value),
        .s_row        (s_row),
        .s_column     (s_column),
        .push         (push),
        .push_desc    (push_desc),
        .q_full       (q_full)
    );

    lnws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    lnws_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_desc         (q_desc),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_nibble       (m_nibble),
        .m_reg_select   (m_reg_select),
        .m_pre_wait_us  (m_pre_wait_us),
        .m_post_wait_us (m_post_wait_us),
        .m_last         (m_last)
    );

endmodule
